// ===== rtl/regional_minima_plateau_count_macros.svh =====
// Assertion macros for the regional minima plateau counter.
`ifndef REGIONAL_MINIMA_PLATEAU_COUNT_MACROS_SVH
`define REGIONAL_MINIMA_PLATEAU_COUNT_MACROS_SVH
`ifndef ASSERT_OFF
`define RMPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RMPC_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMPC_ASSERT(label, clk, rst, prop, msg)
`define RMPC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/rmpc_pkg.sv =====
package rmpc_pkg;
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;
   localparam int DEF_HEIGHT_BITS = 14;
   localparam int DIM_BITS = 7;
   localparam int REG_ROW_COUNT = 0;
   localparam int REG_COL_COUNT = 1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_SCAN_RD,
      OP_SEED,
      OP_POP,
      OP_HREAD,
      OP_NB_RD,
      OP_NB_CHK,
      OP_COUNT,
      OP_NEXT,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type  op;
      logic [1:0] nb;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic scan_visited;
      logic scan_done;
      logic stack_empty;
      logic nb_exists;
   } status_type;
endpackage

// ===== rtl/rmpc_datapath.sv =====
module rmpc_datapath #(
   parameter int MAX_ROWS = rmpc_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = rmpc_pkg::DEF_MAX_COLS,
   parameter int HEIGHT_BITS = rmpc_pkg::DEF_HEIGHT_BITS
) (
   input  logic clock,
   input  logic reset,
   input  rmpc_pkg::cmd_type cmd,
   input  logic [HEIGHT_BITS-1:0] in_height,
   input  logic [rmpc_pkg::DIM_BITS-1:0] row_reg,
   input  logic [rmpc_pkg::DIM_BITS-1:0] col_reg,
   output rmpc_pkg::status_type status,
   output logic [$clog2(MAX_ROWS*MAX_COLS+1)-1:0] count_out
);
   import rmpc_pkg::*;
   localparam int CAP = MAX_ROWS * MAX_COLS;
   localparam int AW = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int CW = $clog2(CAP + 1);
   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int KW = $clog2(MAX_COLS + 1);
   localparam int RI = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int KI = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int PW = RI + KI;

   logic [HEIGHT_BITS-1:0] hmem [CAP];
   logic [PW-1:0] smem [CAP];
   logic vmem [CAP];

   logic [RW-1:0] rows;
   logic [KW-1:0] cols;
   logic [CW-1:0] n_cells;
   logic [CW-1:0] load_pos_ff, scan_ff, depth_ff, count_ff;
   logic [RI-1:0] pr_ff, sr_ff, qr;
   logic [KI-1:0] pc_ff, sc_ff, qc;
   logic [AW-1:0] p_lin, p_ff, q_ff, nb_addr;
   logic [PW-1:0] qrc_ff;
   logic [HEIGHT_BITS-1:0] h_ff, hrd_ff;
   logic vrd_ff, outlet_ff;
   logic nb_ok;
   logic [CW-1:0] vclr_ff;

   always_comb begin
      if (row_reg == '0) rows = RW'(1);
      else if ({1'b0, row_reg} > (DIM_BITS+1)'(MAX_ROWS)) rows = RW'(MAX_ROWS);
      else rows = RW'(row_reg);
      if (col_reg == '0) cols = KW'(1);
      else if ({1'b0, col_reg} > (DIM_BITS+1)'(MAX_COLS)) cols = KW'(MAX_COLS);
      else cols = KW'(col_reg);
   end
   assign n_cells = CW'(rows) * CW'(cols);

   // The stack holds row and column, so the linear index needs only one small multiply.
   assign p_lin = AW'(CW'(pr_ff) * CW'(cols) + CW'(pc_ff));

   always_comb begin
      nb_addr = p_ff;
      nb_ok = 1'b0;
      qr = pr_ff;
      qc = pc_ff;
      unique case (cmd.nb)
         2'd0: begin
            nb_ok = (RW'(pr_ff) + RW'(1)) < rows;
            nb_addr = p_ff + AW'(cols);
            qr = pr_ff + RI'(1);
         end
         2'd1: begin
            nb_ok = pr_ff != '0;
            nb_addr = p_ff - AW'(cols);
            qr = pr_ff - RI'(1);
         end
         2'd2: begin
            nb_ok = (KW'(pc_ff) + KW'(1)) < cols;
            nb_addr = p_ff + AW'(1);
            qc = pc_ff + KI'(1);
         end
         default: begin
            nb_ok = pc_ff != '0;
            nb_addr = p_ff - AW'(1);
            qc = pc_ff - KI'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && load_pos_ff < n_cells) hmem[load_pos_ff[AW-1:0]] <= in_height;
      if (cmd.op == OP_CLEAR) vmem[vclr_ff[AW-1:0]] <= 1'b0;
      if (cmd.op == OP_SEED) begin
         vmem[scan_ff[AW-1:0]] <= 1'b1;
         smem[0] <= {sr_ff, sc_ff};
      end
      if (cmd.op == OP_NB_CHK && hrd_ff == h_ff && !vrd_ff && depth_ff < CW'(CAP)) begin
         vmem[q_ff] <= 1'b1;
         smem[depth_ff[AW-1:0]] <= qrc_ff;
      end
      unique case (cmd.op)
         OP_SCAN_RD: begin
            vrd_ff <= vmem[scan_ff[AW-1:0]];
         end
         OP_POP: begin
            {pr_ff, pc_ff} <= smem[AW'(depth_ff - CW'(1))];
         end
         OP_HREAD: begin
            h_ff <= hmem[p_lin];
            p_ff <= p_lin;
         end
         OP_NB_RD: begin
            hrd_ff <= hmem[nb_addr];
            vrd_ff <= vmem[nb_addr];
            q_ff <= nb_addr;
            qrc_ff <= {qr, qc};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         scan_ff <= '0;
         depth_ff <= '0;
         count_ff <= '0;
         outlet_ff <= 1'b0;
         vclr_ff <= '0;
      end else begin
         unique case (cmd.op)
            OP_LOAD: if (load_pos_ff < n_cells) load_pos_ff <= load_pos_ff + CW'(1);
            OP_CLEAR: vclr_ff <= vclr_ff + CW'(1);
            OP_SEED: begin
               depth_ff <= CW'(1);
               outlet_ff <= 1'b0;
            end
            OP_POP: depth_ff <= depth_ff - CW'(1);
            OP_NB_CHK: begin
               if (hrd_ff < h_ff) outlet_ff <= 1'b1;
               else if (hrd_ff == h_ff && !vrd_ff && depth_ff < CW'(CAP))
                  depth_ff <= depth_ff + CW'(1);
            end
            OP_COUNT: if (!outlet_ff) count_ff <= count_ff + CW'(1);
            OP_NEXT: begin
               scan_ff <= scan_ff + CW'(1);
               if (KW'(sc_ff) + KW'(1) >= cols) begin
                  sc_ff <= '0;
                  sr_ff <= sr_ff + RI'(1);
               end else sc_ff <= sc_ff + KI'(1);
            end
            OP_FINISH: begin
               scan_ff <= '0;
               load_pos_ff <= '0;
               vclr_ff <= '0;
               count_ff <= '0;
            end
            default: begin
            end
         endcase
         if (cmd.op == OP_CLEAR && vclr_ff == '0) begin
            count_ff <= '0;
            sr_ff <= '0;
            sc_ff <= '0;
            scan_ff <= '0;
         end
      end
   end

   assign status.clear_done = vclr_ff >= CW'(CAP - 1);
   assign status.scan_visited = vrd_ff;
   assign status.scan_done = scan_ff >= n_cells;
   assign status.stack_empty = depth_ff == '0;
   assign status.nb_exists = nb_ok;
   assign count_out = count_ff;
endmodule

// ===== rtl/rmpc_control.sv =====
module rmpc_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_last_cell,
   input  logic rsp_stall,
   input  rmpc_pkg::status_type status,
   output rmpc_pkg::cmd_type cmd,
   output logic req_stall,
   output logic rsp_valid,
   output logic count_latch
);
   import rmpc_pkg::*;
   typedef enum logic [3:0] {
      S_LOAD, S_CLEAR, S_SCAN, S_SCAN_CHK, S_POP, S_HREAD, S_NBRD, S_NBCHK,
      S_COUNT, S_NEXT, S_OUT
   } state_type;
   state_type state_ff;
   logic [1:0] nb_ff;
   logic rsp_valid_ff;

   always_comb begin
      cmd.op = OP_NONE;
      cmd.nb = nb_ff;
      unique case (state_ff)
         S_LOAD: cmd.op = req_valid ? OP_LOAD : OP_NONE;
         S_CLEAR: cmd.op = OP_CLEAR;
         S_SCAN: cmd.op = status.scan_done ? OP_NONE : OP_SCAN_RD;
         S_SCAN_CHK: cmd.op = status.scan_visited ? OP_NEXT : OP_SEED;
         S_POP: cmd.op = status.stack_empty ? OP_COUNT : OP_POP;
         S_HREAD: cmd.op = OP_HREAD;
         S_NBRD: cmd.op = status.nb_exists ? OP_NB_RD : OP_NONE;
         S_NBCHK: cmd.op = OP_NB_CHK;
         S_COUNT: cmd.op = OP_NEXT;
         S_OUT: cmd.op = rsp_valid_ff ? OP_NONE : OP_FINISH;
         default: cmd.op = OP_NONE;
      endcase
   end

   assign req_stall = state_ff != S_LOAD;
   assign rsp_valid = rsp_valid_ff;
   assign count_latch = state_ff == S_OUT && !rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         nb_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_LOAD: if (req_valid && req_last_cell) state_ff <= S_CLEAR;
            S_CLEAR: if (status.clear_done) state_ff <= S_SCAN;
            S_SCAN: state_ff <= status.scan_done ? S_OUT : S_SCAN_CHK;
            S_SCAN_CHK: state_ff <= status.scan_visited ? S_SCAN : S_POP;
            S_POP: begin
               nb_ff <= '0;
               state_ff <= status.stack_empty ? S_COUNT : S_HREAD;
            end
            S_HREAD: state_ff <= S_NBRD;
            S_NBRD: state_ff <= status.nb_exists ? S_NBCHK : (nb_ff == 2'd3 ? S_POP : S_NBRD);
            S_NBCHK: begin
               nb_ff <= nb_ff + 2'd1;
               state_ff <= nb_ff == 2'd3 ? S_POP : S_NBRD;
            end
            S_COUNT: state_ff <= S_SCAN;
            S_OUT: if (!rsp_valid_ff) begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_LOAD;
            end
            default: state_ff <= S_LOAD;
         endcase
         if (state_ff == S_NBRD && !status.nb_exists) nb_ff <= nb_ff + 2'd1;
      end
   end
endmodule

// ===== rtl/regional_minima_plateau_count.sv =====
// Cells are taken one per cycle while the block waits for a grid; the last cell starts a count.
// The count first clears the visited map, then scans every cell, walks the plateau of each
// cell not yet visited while checking its neighbors inside the grid, counts each plateau
// that has no lower neighbor, and then presents the result.
// Throughput is one grid per load and count; a waiting result holds back only the delivery of the next result.
// Reset is synchronous, active high, and clears control state; both registers reset to 64.
`include "regional_minima_plateau_count_macros.svh"
module regional_minima_plateau_count #(
   parameter int MAX_ROWS = rmpc_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = rmpc_pkg::DEF_MAX_COLS,
   parameter int HEIGHT_BITS = rmpc_pkg::DEF_HEIGHT_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [HEIGHT_BITS-1:0] req_cell_height,
   input  logic req_last_cell,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [12:0] rsp_basin_count,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import rmpc_pkg::*;
   localparam int CW = $clog2(MAX_ROWS * MAX_COLS + 1);
   logic [DIM_BITS-1:0] row_ff, col_ff;
   cmd_type cmd;
   status_type status;
   logic [CW-1:0] count;
   logic count_latch;
   logic [12:0] result_ff;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= DIM_BITS'(64);
         col_ff <= DIM_BITS'(64);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            1'b0: if (csr_paddr[1:0] == 2'd0) row_ff <= csr_pwdata[DIM_BITS-1:0];
            default: if (csr_paddr[1:0] == 2'd0) col_ff <= csr_pwdata[DIM_BITS-1:0];
         endcase
      end
   end
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == 3'(4 * REG_ROW_COUNT)) csr_prdata = 32'(row_ff);
      else if (csr_paddr == 3'(4 * REG_COL_COUNT)) csr_prdata = 32'(col_ff);
   end

   always_ff @(posedge clock) begin
      if (count_latch) result_ff <= 13'(count);
   end
   assign rsp_basin_count = result_ff;

   rmpc_control u_control (
      .clock, .reset, .req_valid, .req_last_cell, .rsp_stall, .status, .cmd,
      .req_stall, .rsp_valid, .count_latch
   );
   rmpc_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .HEIGHT_BITS(HEIGHT_BITS))
   u_datapath (
      .clock, .reset, .cmd, .in_height(req_cell_height), .row_reg(row_ff), .col_reg(col_ff),
      .status, .count_out(count)
   );

   `RMPC_ASSERT_NORST(a_pready_high, clock, csr_pready, "csr_pready low")
   `RMPC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_basin_count), "result dropped")
endmodule

// ===== bench/tb_regional_minima_plateau_count.sv =====
`timescale 1ns / 1ps
module tb_regional_minima_plateau_count;
   import rmpc_pkg::*;

   localparam int CELL_CAP = DEF_MAX_ROWS * DEF_MAX_COLS;
   localparam int IDLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [DEF_HEIGHT_BITS-1:0] req_cell_height = '0;
   logic req_last_cell = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [12:0] rsp_basin_count;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   regional_minima_plateau_count u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cell_height(req_cell_height), .req_last_cell(req_last_cell),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_basin_count(rsp_basin_count),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   logic [DEF_HEIGHT_BITS-1:0] height_copy [0:CELL_CAP-1];
   bit cell_written [0:CELL_CAP-1];
   int load_index = 0;
   logic [DIM_BITS-1:0] rows_reg = 7'd64;
   logic [DIM_BITS-1:0] cols_reg = 7'd64;
   logic [12:0] basin_counts_due [$];
   int errors = 0;
   int cells_sent = 0;
   int grids_sent = 0;
   int counts_seen = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int stall_phase = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int clamp_dim(logic [DIM_BITS-1:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic int grid_size();
      return clamp_dim(rows_reg, DEF_MAX_ROWS) * clamp_dim(cols_reg, DEF_MAX_COLS);
   endfunction

   function automatic logic [12:0] count_basins();
      bit seen [0:CELL_CAP-1];
      int walk [0:CELL_CAP-1];
      int rows, cols, depth, p, r, c, q, k;
      logic [DEF_HEIGHT_BITS-1:0] h;
      bit outlet;
      logic [12:0] total;
      rows = clamp_dim(rows_reg, DEF_MAX_ROWS);
      cols = clamp_dim(cols_reg, DEF_MAX_COLS);
      total = 0;
      for (int i = 0; i < CELL_CAP; i++) seen[i] = 1'b0;
      for (int s = 0; s < rows * cols; s++) begin
         if (seen[s]) continue;
         outlet = 1'b0;
         seen[s] = 1'b1;
         walk[0] = s;
         depth = 1;
         while (depth > 0) begin
            depth--;
            p = walk[depth];
            r = p / cols;
            c = p % cols;
            h = height_copy[p];
            for (k = 0; k < 4; k++) begin
               q = -1;
               if (k == 0 && r + 1 < rows) q = p + cols;
               if (k == 1 && r > 0) q = p - cols;
               if (k == 2 && c + 1 < cols) q = p + 1;
               if (k == 3 && c > 0) q = p - 1;
               if (q < 0) continue;
               if (height_copy[q] < h) begin
                  outlet = 1'b1;
               end else if (height_copy[q] == h && !seen[q] && depth < CELL_CAP) begin
                  seen[q] = 1'b1;
                  walk[depth] = q;
                  depth++;
               end
            end
         end
         if (!outlet) total++;
      end
      return total;
   endfunction

   function automatic void predict_cell(logic [DEF_HEIGHT_BITS-1:0] h, logic last);
      if (load_index < grid_size()) begin
         height_copy[load_index] = h;
         cell_written[load_index] = 1'b1;
         load_index++;
      end
      if (last) begin
         basin_counts_due = {basin_counts_due, count_basins()};
         load_index = 0;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         counts_seen++;
         if (basin_counts_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result basin_count=%0d", $time, rsp_basin_count);
         end else begin
            if (rsp_basin_count !== basin_counts_due[0]) begin
               errors++;
               $display("%0t: basin_count expected %0d actual %0d",
                        $time, basin_counts_due[0], rsp_basin_count);
            end
            void'(basin_counts_due.pop_front());
         end
      end
   end

   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 600;
      if (stall_phase < 200) begin
         rsp_stall <= 1'b0;
      end else if (stall_phase < 400) begin
         rsp_stall <= ($urandom_range(0, 99) < 40);
      end else begin
         rsp_stall <= ((stall_phase / 37) % 2 == 1);
      end
   end

   task automatic send_request(logic [DEF_HEIGHT_BITS-1:0] h, logic last);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
      end
      burst_left--;
      req_valid = 1'b1;
      req_cell_height = h;
      req_last_cell = last;
      while (req_stall) @(negedge clock);
      @(posedge clock);
      predict_cell(h, last);
      cells_sent++;
      if (last) grids_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (basin_counts_due.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(int idx, logic [DIM_BITS-1:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = 3'(4 * idx);
      csr_pwdata = {25'd0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      if (idx == REG_ROW_COUNT) rows_reg = value;
      if (idx == REG_COL_COUNT) cols_reg = value;
   endtask

   task automatic set_shape(logic [DIM_BITS-1:0] r, logic [DIM_BITS-1:0] c);
      wait_idle();
      write_reg(REG_ROW_COUNT, r);
      write_reg(REG_COL_COUNT, c);
   endtask

   task automatic send_list(int heights [$]);
      foreach (heights[i])
         send_request(DEF_HEIGHT_BITS'(heights[i]), i == heights.size() - 1);
   endtask

   task automatic test_single_cell();
      set_shape(7'd0, 7'd0);
      send_list('{0});
      send_list('{16383});
      send_list('{5, 7, 9});
   endtask

   task automatic test_plateaus();
      set_shape(7'd3, 7'd3);
      send_list('{2, 2, 5, 2, 9, 1, 10000, 16383, 1});
      send_list('{7, 7, 7, 7, 7, 7, 7, 7, 7});
      send_list('{3, 0, 3, 3});
      set_shape(7'd4, 7'd1);
      send_list('{10000, 4, 4, 9});
   endtask

   function automatic logic [DEF_HEIGHT_BITS-1:0] pick_height(int mode);
      case (mode)
         0: return DEF_HEIGHT_BITS'($urandom_range(0, 3));
         1: return DEF_HEIGHT_BITS'($urandom_range(0, 10000));
         2: return DEF_HEIGHT_BITS'($urandom_range(0, 16383));
         default: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return DEF_HEIGHT_BITS'(10000);
               2: return DEF_HEIGHT_BITS'(16383);
               default: return DEF_HEIGHT_BITS'($urandom_range(9990, 10010));
            endcase
         end
      endcase
   endfunction

   function automatic logic [DIM_BITS-1:0] encode_dim(int d);
      if (d == 1 && $urandom_range(0, 2) == 0) return '0;
      if (d == 64 && $urandom_range(0, 1) == 0) return DIM_BITS'($urandom_range(65, 127));
      return DIM_BITS'(d);
   endfunction

   task automatic test_random_grids();
      int r, c, n, len, mode, big_grids;
      bit covered;
      big_grids = 0;
      while (cells_sent < 1500 || grids_sent < 40) begin
         case ($urandom_range(0, 19))
            0: begin
               if (big_grids < 1) begin
                  r = 24; c = 24; big_grids++;
               end else begin
                  r = 8; c = 8;
               end
            end
            1: begin r = 1; c = $urandom_range(1, 64); end
            2: begin r = $urandom_range(1, 64); c = 1; end
            default: begin r = $urandom_range(1, 8); c = $urandom_range(1, 8); end
         endcase
         if (grids_sent % 3 == 0 || r * c != grid_size()) set_shape(encode_dim(r), encode_dim(c));
         n = grid_size();
         len = n;
         case ($urandom_range(0, 9))
            0: len = n + $urandom_range(1, 4);
            1: begin
               covered = 1'b1;
               for (int i = 0; i < n; i++) if (!cell_written[i]) covered = 1'b0;
               if (covered && n > 1) len = $urandom_range(1, n - 1);
            end
            default: ;
         endcase
         mode = $urandom_range(0, 3);
         for (int i = 0; i < len; i++) send_request(pick_height(mode), i == len - 1);
      end
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;
      test_single_cell();
      test_plateaus();
      test_random_grids();
      wait_idle();
      $display("Sent %0d cells in %0d grids, checked %0d basin counts.",
               cells_sent, grids_sent, counts_seen);
      $display("Shapes ranged from one cell to 64 cells on a side, with clamped register values.");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
